// ----- rtl/lsocs_pkg.sv -----
// Package for the load switch overcurrent supervisor.
// Holds phase, status, command and register codes used by the RTL; the checker uses the phase and status codes.
// No dependencies.
package lsocs_pkg;

    localparam int unsigned WAIT_TICKS_DEF = 100;
    localparam int unsigned WAIT_W         = 7;
    localparam int unsigned DELAY_W        = 10;
    localparam int unsigned CFG_INDEX_W    = 2;
    localparam int unsigned CFG_DATA_W     = 10;
    localparam int unsigned S_TDATA_W      = 8;
    localparam int unsigned M_TDATA_W      = 16;

    typedef enum logic [2:0] {
        PH_OFF     = 3'd0,
        PH_WAIT    = 3'd1,
        PH_READY   = 3'd2,
        PH_DELAY   = 3'd3,
        PH_SETTLED = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        ST_OK       = 2'd0,
        ST_STUCK    = 2'd1,
        ST_BUSY     = 2'd2,
        ST_READFAIL = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CMD_TICK    = 2'd0,
        CMD_ENABLE  = 2'd1,
        CMD_DISABLE = 2'd2,
        CMD_UNUSED  = 2'd3
    } cmd_t;

    localparam logic [CFG_INDEX_W-1:0] REG_TRIP_DELAY   = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_FLAG_HIGH    = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_ENABLE_HIGH  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_PULL_PRESENT = 2'd3;

endpackage

// ----- rtl/load_switch_overcurrent_supervisor_unit.sv -----
// Top level of the load switch overcurrent supervisor.
// Depends on lsocs_pkg.
//
// Channel  Dir  Handshake            Content
// s_       in   s_tvalid/s_tready    one request: command, flag level, read error
// m_       out  m_tvalid/m_tready    one result per request
// cfg_     in   cfg_valid/cfg_ready  register index and write data
//
// Each request's result is in the output register in the cycle after the
// request is taken; a new request can be taken every cycle unless m_tready stalls.
// s_tready is high while the output register is empty or being taken.
// aresetn is synchronous: it clears phase, counters and m_tvalid, and sets the config registers to their defaults.
// cfg_ready is always high.
module load_switch_overcurrent_supervisor_unit #(
    parameter int unsigned WAIT_TICKS = lsocs_pkg::WAIT_TICKS_DEF
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_tvalid,
    output logic                                s_tready,
    // [1:0] command, [2] flag_level, [3] flag_read_error, [7:4] zero
    input  logic [lsocs_pkg::S_TDATA_W-1:0]     s_tdata,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    // [0] enable_pin, [1] pull_up_on, [4:2] phase, [5] oc_notify,
    // [7:6] cmd_status, [8] output_on, [15:9] zero
    output logic [lsocs_pkg::M_TDATA_W-1:0]     m_tdata,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [lsocs_pkg::CFG_INDEX_W-1:0]   cfg_index,
    input  logic [lsocs_pkg::CFG_DATA_W-1:0]    cfg_data
);

    localparam int unsigned WAIT_W  = lsocs_pkg::WAIT_W;
    localparam int unsigned DELAY_W = lsocs_pkg::DELAY_W;
    localparam int unsigned M_TDATA_W_L = lsocs_pkg::M_TDATA_W;
    localparam logic [WAIT_W-1:0] WAIT_LOAD_RAW = WAIT_W'(WAIT_TICKS);
    localparam logic [WAIT_W-1:0] WAIT_LOAD =
        (WAIT_LOAD_RAW == '0) ? WAIT_W'(1) : WAIT_LOAD_RAW;

    logic [DELAY_W-1:0] trip_delay_reg;
    logic               flag_high_reg;
    logic               enable_high_reg;
    logic               pull_present_reg;

    lsocs_pkg::phase_t  phase_reg, phase_next;
    logic [DELAY_W-1:0] delay_count_reg, delay_count_next;
    logic [WAIT_W-1:0]  wait_count_reg, wait_count_next;
    logic               switch_driven_reg, switch_driven_next;

    logic               m_tvalid_reg;
    logic [M_TDATA_W_L-1:0] m_tdata_reg, m_tdata_next;

    logic               accept;
    lsocs_pkg::cmd_t    cmd;
    logic               level;
    logic               rd_err;
    logic               active;
    logic [WAIT_W-1:0]  wait_dec;
    logic [DELAY_W-1:0] delay_dec;
    logic [DELAY_W-1:0] delay_load;
    lsocs_pkg::status_t status;
    logic               notify;

    assign cfg_ready = 1'b1;
    assign s_tready  = !m_tvalid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign m_tvalid  = m_tvalid_reg;
    assign m_tdata   = m_tdata_reg;

    assign cmd        = lsocs_pkg::cmd_t'(s_tdata[1:0]);
    assign level      = s_tdata[2];
    assign rd_err     = s_tdata[3];
    assign active     = flag_high_reg ? level : !level;
    assign wait_dec   = wait_count_reg - WAIT_W'(1);
    assign delay_dec  = delay_count_reg - DELAY_W'(1);
    assign delay_load = (trip_delay_reg == '0) ? DELAY_W'(1) : trip_delay_reg;

    // next state
    always_comb begin
        phase_next         = phase_reg;
        delay_count_next   = delay_count_reg;
        wait_count_next    = wait_count_reg;
        switch_driven_next = switch_driven_reg;
        case (cmd)
            lsocs_pkg::CMD_ENABLE: begin
                if (phase_reg == lsocs_pkg::PH_OFF) begin
                    phase_next      = lsocs_pkg::PH_WAIT;
                    wait_count_next = WAIT_LOAD;
                end
            end
            lsocs_pkg::CMD_DISABLE: begin
                if (phase_reg != lsocs_pkg::PH_OFF && phase_reg != lsocs_pkg::PH_WAIT) begin
                    phase_next         = lsocs_pkg::PH_OFF;
                    delay_count_next   = '0;
                    wait_count_next    = '0;
                    switch_driven_next = 1'b0;
                end
            end
            lsocs_pkg::CMD_TICK: begin
                case (phase_reg)
                    lsocs_pkg::PH_WAIT: begin
                        if (rd_err || (active && wait_dec == '0)) begin
                            phase_next         = lsocs_pkg::PH_OFF;
                            delay_count_next   = '0;
                            wait_count_next    = '0;
                            switch_driven_next = 1'b0;
                        end else if (!active) begin
                            phase_next         = lsocs_pkg::PH_READY;
                            wait_count_next    = '0;
                            switch_driven_next = 1'b1;
                        end else begin
                            wait_count_next = wait_dec;
                        end
                    end
                    lsocs_pkg::PH_READY: begin
                        if (active) begin
                            phase_next       = lsocs_pkg::PH_DELAY;
                            delay_count_next = delay_load;
                        end
                    end
                    lsocs_pkg::PH_DELAY: begin
                        delay_count_next = delay_dec;
                        if (delay_dec == '0) begin
                            phase_next = (rd_err || active) ? lsocs_pkg::PH_SETTLED
                                                            : lsocs_pkg::PH_READY;
                        end
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase
    end

    // outputs
    always_comb begin
        status = lsocs_pkg::ST_OK;
        notify = 1'b0;
        case (cmd)
            lsocs_pkg::CMD_ENABLE, lsocs_pkg::CMD_DISABLE: begin
                if (phase_reg == lsocs_pkg::PH_WAIT) begin
                    status = lsocs_pkg::ST_BUSY;
                end
            end
            lsocs_pkg::CMD_TICK: begin
                case (phase_reg)
                    lsocs_pkg::PH_WAIT: begin
                        if (rd_err) begin
                            status = lsocs_pkg::ST_READFAIL;
                        end else if (active && wait_dec == '0) begin
                            status = lsocs_pkg::ST_STUCK;
                        end
                    end
                    lsocs_pkg::PH_DELAY: begin
                        notify = (delay_dec == '0) && (rd_err || active);
                    end
                    default: ;
                endcase
            end
            default: ;
        endcase

        m_tdata_next      = '0;
        m_tdata_next[0]   = switch_driven_next ? enable_high_reg : !enable_high_reg;
        m_tdata_next[1]   = pull_present_reg && (phase_next != lsocs_pkg::PH_OFF);
        m_tdata_next[4:2] = phase_next;
        m_tdata_next[5]   = notify;
        m_tdata_next[7:6] = status;
        m_tdata_next[8]   = (phase_next == lsocs_pkg::PH_READY)
                         || (phase_next == lsocs_pkg::PH_DELAY)
                         || (phase_next == lsocs_pkg::PH_SETTLED);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            trip_delay_reg    <= DELAY_W'(1);
            flag_high_reg     <= 1'b0;
            enable_high_reg   <= 1'b1;
            pull_present_reg  <= 1'b1;
            phase_reg         <= lsocs_pkg::PH_OFF;
            delay_count_reg   <= '0;
            wait_count_reg    <= '0;
            switch_driven_reg <= 1'b0;
            m_tvalid_reg      <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    lsocs_pkg::REG_TRIP_DELAY:   trip_delay_reg   <= cfg_data;
                    lsocs_pkg::REG_FLAG_HIGH:    flag_high_reg    <= cfg_data[0];
                    lsocs_pkg::REG_ENABLE_HIGH:  enable_high_reg  <= cfg_data[0];
                    lsocs_pkg::REG_PULL_PRESENT: pull_present_reg <= cfg_data[0];
                    default: ;
                endcase
            end
            if (accept) begin
                phase_reg         <= phase_next;
                delay_count_reg   <= delay_count_next;
                wait_count_reg    <= wait_count_next;
                switch_driven_reg <= switch_driven_next;
                m_tvalid_reg      <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg      <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            m_tdata_reg <= m_tdata_next;
        end
    end

endmodule

// ----- rtl/lsocs_checker.sv -----
// Port checker for the load switch overcurrent supervisor, bound to the top level.
// Depends on lsocs_pkg and load_switch_overcurrent_supervisor_unit.
// Watches the result stream for consistency between phase, notify and status.
module lsocs_checker (
    input logic                               aclk,
    input logic                               aresetn,
    input logic                               s_tready,
    input logic                               m_tvalid,
    input logic                               m_tready,
    input logic [lsocs_pkg::M_TDATA_W-1:0]    m_tdata
);

    // hold a stalled result
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    // accept whenever the output register is free
    a_ready_free: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("request refused with output register empty");

    a_notify_settled: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[5] |-> m_tdata[4:2] == lsocs_pkg::PH_SETTLED)
        else $error("notify outside settled phase");

    a_busy_wait: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[7:6] == lsocs_pkg::ST_BUSY
        |-> m_tdata[4:2] == lsocs_pkg::PH_WAIT)
        else $error("busy status outside pull-up wait");

    a_output_on: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[8] == (m_tdata[4:2] == lsocs_pkg::PH_READY
                                 || m_tdata[4:2] == lsocs_pkg::PH_DELAY
                                 || m_tdata[4:2] == lsocs_pkg::PH_SETTLED))
        else $error("output_on disagrees with phase");

endmodule

bind load_switch_overcurrent_supervisor_unit lsocs_checker u_lsocs_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
